// ----- sv/sas_pkg.sv -----
// Shared types and constants for the sorted array set block.
// Used by sas_cell and sorted_array_set_core; depends on nothing.
package sas_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int COUNT_W     = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DEC,
    ST_UPD
  } sas_state_t;

  typedef struct packed {
    logic cap;
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ----- sv/sorted_array_set_core.sv -----
// Top level of the sorted array set: control sequencer and a row of key cells.
// Depends on sas_pkg and sas_cell.
//
// Usage: each input transfer carries a command (add, remove, query; code 3
// acts as a query) and a signed 32-bit key. Every input transfer yields
// exactly one output transfer with the present flag, the full flag for a
// refused add, and the key count after the command.
// Keys sit in a row of cells in ascending order; an insert or delete shifts
// the cells from the key's position upward by one place, all in the same cycle.
// The result passes through the compare, decide and update steps into the output register.
// The sequencer handles one item at a time through its compare, decide and
// update steps, and takes no new item until the current one is through.
// An output register holds a finished result, so the next item is accepted
// while it waits. If the receiver stalls, the next item stops in its update
// step until the output register is free; no result is lost.
// Reset empties the set at once; cell contents need no clearing pass.
module sorted_array_set_core import sas_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata fields from bit 0: cmd[1:0], key[33:2], zero pad to 40 bits
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata fields from bit 0: present[0], full_res[1], count[10:2], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  localparam int CW = $clog2(CAPACITY + 1);

  sas_state_t         state_r, state_nxt;
  logic [1:0]         cmd_r;
  logic signed [31:0] key_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic               hit_r, full_r, ins_r, del_r;
  logic               out_valid_r, out_valid_nxt;
  logic               present_r, full_res_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [CW+COUNT_W-1:0] count_ext;
  logic               out_free;
  logic               hit_w, full_w;
  cell_ctl_t          ctl;

  logic signed [31:0] key_w [CAPACITY];
  logic [CAPACITY-1:0] lt_w;
  logic [CAPACITY-1:0] eq_w;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lkey, rkey;
    logic               llt;
    if (i == 0) begin : g_first
      assign lkey = key_r;
      assign llt  = 1'b1;
    end else begin : g_mid
      assign lkey = key_w[i-1];
      assign llt  = lt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rkey = key_w[i];
    end else begin : g_inner
      assign rkey = key_w[i+1];
    end
    sas_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .k         (key_r),
      .count     (count_r),
      .left_key  (lkey),
      .left_lt   (llt),
      .right_key (rkey),
      .key_o     (key_w[i]),
      .lt_o      (lt_w[i]),
      .eq_o      (eq_w[i])
    );
  end

  assign out_free = !out_valid_r || out_tready;
  assign hit_w    = |eq_w;
  assign full_w   = count_r >= CW'(CAPACITY);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_DEC;
      ST_DEC:  state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CMP:  ctl.cap = 1'b1;
      ST_DEC:  ;
      ST_UPD: begin
        ctl.ins = out_free && ins_r;
        ctl.del = out_free && del_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_UPD && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cmd_r <= in_tdata[1:0];
      key_r <= in_tdata[33:2];
    end
    if (state_r == ST_DEC) begin
      hit_r  <= hit_w;
      full_r <= (cmd_r == CMD_ADD) && !hit_w && full_w;
      ins_r  <= (cmd_r == CMD_ADD) && !hit_w && !full_w;
      del_r  <= (cmd_r == CMD_REMOVE) && hit_w;
    end
    if (state_r == ST_UPD && out_free) begin
      present_r   <= hit_r;
      full_res_r  <= full_r;
      out_count_r <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - COUNT_W - 2){1'b0}}, out_count_r, full_res_r, present_r};

endmodule

// ----- sv/sas_cell.sv -----
// One storage cell of the sorted key row: holds a key and its compare flags.
// Depends on sas_pkg for the control struct.
module sas_cell import sas_pkg::*; #(
  parameter int CW  = 9,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] k,
  input  logic [CW-1:0]      count,
  input  logic signed [31:0] left_key,
  input  logic               left_lt,
  input  logic signed [31:0] right_key,
  output logic signed [31:0] key_o,
  output logic               lt_o,
  output logic               eq_o
);

  logic signed [31:0] key_r, key_nxt;
  logic               lt_r, lt_nxt;
  logic               eq_r, eq_nxt;
  logic               valid;

  assign valid = count > CW'(IDX);

  always_comb begin
    key_nxt = key_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctl.cap) begin
      lt_nxt = valid && (key_r < k);
      eq_nxt = valid && (key_r == k);
    end
    if (ctl.ins && !lt_r) begin
      key_nxt = left_lt ? k : left_key;
    end
    if (ctl.del && !lt_r) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

  assign key_o = key_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule
